>>> rtl/maf_pkg.sv
// Shared types, constants and the step sequences for the multimode audio filter.
// Used by maf_ctrl, maf_dp and the top level; depends on nothing else.
`timescale 1ns / 1ps

package maf_pkg;

    localparam int COEF_W   = 24;
    localparam int RES_W    = 17;
    localparam int PC_W     = 4;
    localparam int Q16_FRAC = 16;
    localparam logic [RES_W-1:0] Q16_ONE = 17'd65536;
    localparam logic [15:0] K_099 = 16'd64881;
    localparam logic [15:0] K_095 = 16'd62259;

    typedef enum logic [2:0] {
        CFG_MODEL  = 3'd0,
        CFG_RESP   = 3'd1,
        CFG_OSF    = 3'd2,
        CFG_GCOEF  = 3'd3,
        CFG_LCOEF  = 3'd4,
        CFG_RES    = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MDL_SVF   = 3'd0,
        MDL_DLAD  = 3'd1,
        MDL_TPOLE = 3'd2,
        MDL_INTEG = 3'd3,
        MDL_OLAD  = 3'd4
    } t_model;

    typedef enum logic [1:0] {
        RSP_LP    = 2'd0,
        RSP_HP    = 2'd1,
        RSP_BP    = 2'd2,
        RSP_NOTCH = 2'd3
    } t_resp;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_OUT = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        R_X, R_SLO, R_SBP,
        R_D0, R_D1, R_D2, R_D3,
        R_THP, R_TL1, R_TL2,
        R_IHI, R_ILO,
        R_O0, R_O1, R_O2, R_O3,
        R_T0, R_T1, R_T2,
        R_ZERO
    } t_reg;

    typedef enum logic [2:0] {
        C_G, C_L, C_DAMP, C_K095, C_K099, C_RES4
    } t_coef;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        t_op   op;
        t_reg  dst;
        t_reg  a;
        t_reg  b;
        t_reg  c;
        t_coef coef;
        logic  last;
    } t_uop;

    typedef struct packed {
        logic load_x;
        logic exec;
        t_uop uop;
    } t_dp_cmd;

    // round(res * k / 2^16), ties up
    function automatic logic [RES_W-1:0] q16_scale(input logic [RES_W-1:0] res,
                                                   input logic [15:0] k);
        logic [RES_W+16:0] p;
        begin
            p = (RES_W+17)'(res) * (RES_W+17)'(k) + (RES_W+17)'(32768);
            q16_scale = p[RES_W+15:16];
        end
    endfunction

    function automatic t_uop mk(input t_op op, input t_reg dst, input t_reg a,
                                input t_reg b, input t_reg c, input t_coef coef);
        t_uop u;
        begin
            u.op   = op;
            u.dst  = dst;
            u.a    = a;
            u.b    = b;
            u.c    = c;
            u.coef = coef;
            u.last = (op == OP_OUT);
            mk = u;
        end
    endfunction

    function automatic t_uop ladder_step(input logic [PC_W-1:0] pc, input t_reg s0,
                                         input t_reg s1, input t_reg s2, input t_reg s3);
        t_uop u;
        begin
            case (pc)
                4'd3:  u = mk(OP_SUB, R_T2, R_T1, s0, R_ZERO, C_L);
                4'd4:  u = mk(OP_MUL, R_T2, R_T2, R_ZERO, R_ZERO, C_L);
                4'd5:  u = mk(OP_ADD, s0, s0, R_T2, R_ZERO, C_L);
                4'd6:  u = mk(OP_SUB, R_T2, s0, s1, R_ZERO, C_L);
                4'd7:  u = mk(OP_MUL, R_T2, R_T2, R_ZERO, R_ZERO, C_L);
                4'd8:  u = mk(OP_ADD, s1, s1, R_T2, R_ZERO, C_L);
                4'd9:  u = mk(OP_SUB, R_T2, s1, s2, R_ZERO, C_L);
                4'd10: u = mk(OP_MUL, R_T2, R_T2, R_ZERO, R_ZERO, C_L);
                4'd11: u = mk(OP_ADD, s2, s2, R_T2, R_ZERO, C_L);
                4'd12: u = mk(OP_SUB, R_T2, s2, s3, R_ZERO, C_L);
                4'd13: u = mk(OP_MUL, R_T2, R_T2, R_ZERO, R_ZERO, C_L);
                4'd14: u = mk(OP_ADD, s3, s3, R_T2, R_ZERO, C_L);
                default: u = mk(OP_OUT, R_ZERO, s3, R_ZERO, R_ZERO, C_L);
            endcase
            ladder_step = u;
        end
    endfunction

    // One step per cycle; each sequence's last hands off the result once unstalled.
    function automatic t_uop ucode(input t_model m, input t_resp rsp,
                                   input logic [PC_W-1:0] pc);
        t_uop u;
        begin
            u = mk(OP_OUT, R_ZERO, R_T0, R_ZERO, R_ZERO, C_G);
            case (m)
                MDL_DLAD: begin
                    case (pc)
                        4'd0: u = mk(OP_SUB, R_T0, R_D3, R_D2, R_ZERO, C_RES4);
                        4'd1: u = mk(OP_MUL, R_T0, R_T0, R_ZERO, R_ZERO, C_RES4);
                        4'd2: u = mk(OP_SUB, R_T1, R_X, R_T0, R_ZERO, C_RES4);
                        default: u = ladder_step(pc, R_D0, R_D1, R_D2, R_D3);
                    endcase
                end
                MDL_OLAD: begin
                    case (pc)
                        4'd0: u = mk(OP_MUL, R_T0, R_O3, R_ZERO, R_ZERO, C_K099);
                        4'd1: u = mk(OP_ADD, R_T0, R_T0, R_ZERO, R_ZERO, C_K099);
                        4'd2: u = mk(OP_SUB, R_T1, R_X, R_T0, R_ZERO, C_K099);
                        default: u = ladder_step(pc, R_O0, R_O1, R_O2, R_O3);
                    endcase
                end
                MDL_TPOLE: begin
                    case (pc)
                        4'd0: u = mk(OP_MUL, R_T0, R_TL1, R_ZERO, R_ZERO, C_K095);
                        4'd1: u = mk(OP_SUB, R_THP, R_X, R_THP, R_T0, C_G);
                        4'd2: u = mk(OP_MUL, R_T0, R_THP, R_ZERO, R_ZERO, C_G);
                        4'd3: u = mk(OP_ADD, R_TL1, R_TL1, R_T0, R_ZERO, C_G);
                        4'd4: u = mk(OP_MUL, R_T0, R_TL1, R_ZERO, R_ZERO, C_G);
                        4'd5: u = mk(OP_ADD, R_TL2, R_TL2, R_T0, R_ZERO, C_G);
                        default: u = mk(OP_OUT, R_ZERO, R_TL2, R_ZERO, R_ZERO, C_G);
                    endcase
                end
                MDL_INTEG: begin
                    case (pc)
                        4'd0: u = mk(OP_SUB, R_T0, R_X, R_ILO, R_IHI, C_G);
                        4'd1: u = mk(OP_MUL, R_T0, R_T0, R_ZERO, R_ZERO, C_G);
                        4'd2: u = mk(OP_ADD, R_IHI, R_IHI, R_T0, R_ZERO, C_G);
                        4'd3: u = mk(OP_MUL, R_T0, R_IHI, R_ZERO, R_ZERO, C_G);
                        4'd4: u = mk(OP_ADD, R_ILO, R_ILO, R_T0, R_ZERO, C_G);
                        4'd5: begin
                            case (rsp)
                                RSP_HP: u = mk(OP_OUT, R_ZERO, R_IHI, R_ZERO, R_ZERO, C_G);
                                RSP_BP: u = mk(OP_SUB, R_T0, R_IHI, R_ILO, R_ZERO, C_G);
                                RSP_NOTCH: u = mk(OP_ADD, R_T0, R_ILO, R_IHI, R_ZERO, C_G);
                                default: u = mk(OP_OUT, R_ZERO, R_ILO, R_ZERO, R_ZERO, C_G);
                            endcase
                        end
                        default: u = mk(OP_OUT, R_ZERO, R_T0, R_ZERO, R_ZERO, C_G);
                    endcase
                end
                default: begin
                    case (pc)
                        4'd0: u = mk(OP_MUL, R_T0, R_SBP, R_ZERO, R_ZERO, C_G);
                        4'd1: u = mk(OP_ADD, R_SLO, R_SLO, R_T0, R_ZERO, C_G);
                        4'd2: u = mk(OP_MUL, R_T1, R_SBP, R_ZERO, R_ZERO, C_DAMP);
                        4'd3: u = mk(OP_SUB, R_T2, R_X, R_SLO, R_T1, C_G);
                        4'd4: u = mk(OP_MUL, R_T0, R_T2, R_ZERO, R_ZERO, C_G);
                        4'd5: u = mk(OP_ADD, R_SBP, R_SBP, R_T0, R_ZERO, C_G);
                        4'd6: begin
                            case (rsp)
                                RSP_HP: u = mk(OP_OUT, R_ZERO, R_T2, R_ZERO, R_ZERO, C_G);
                                RSP_BP: u = mk(OP_OUT, R_ZERO, R_SBP, R_ZERO, R_ZERO, C_G);
                                RSP_NOTCH: u = mk(OP_ADD, R_T0, R_SLO, R_T2, R_ZERO, C_G);
                                default: u = mk(OP_OUT, R_ZERO, R_SLO, R_ZERO, R_ZERO, C_G);
                            endcase
                        end
                        default: u = mk(OP_OUT, R_ZERO, R_T0, R_ZERO, R_ZERO, C_G);
                    endcase
                end
            endcase
            ucode = u;
        end
    endfunction

endpackage

>>> rtl/maf_ctrl.sv
// Sequencer for the multimode audio filter: walks the step list of the active model.
// Depends on maf_pkg; drives maf_dp through a command struct.
`timescale 1ns / 1ps

module maf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  maf_pkg::t_model   i_model,
    input  maf_pkg::t_resp    i_resp,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output maf_pkg::t_dp_cmd  o_cmd
);

    maf_pkg::t_state               r_state, n_state;
    logic [maf_pkg::PC_W-1:0]      r_pc, n_pc;
    logic                          r_valid, n_valid;
    maf_pkg::t_uop                 uop;
    logic                          out_busy;
    logic                          exec;

    assign uop      = maf_pkg::ucode(i_model, i_resp, r_pc);
    assign out_busy = r_valid && i_stall;
    assign o_valid  = r_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            maf_pkg::ST_IDLE: begin
                if (i_valid) n_state = maf_pkg::ST_RUN;
            end
            maf_pkg::ST_RUN: begin
                if (uop.last && !out_busy) n_state = maf_pkg::ST_IDLE;
            end
            default: n_state = maf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        exec    = 1'b0;
        n_pc    = r_pc;
        n_valid = r_valid && i_stall;
        case (r_state)
            maf_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                n_pc    = '0;
            end
            maf_pkg::ST_RUN: begin
                // hold the final step while the previous result is still unread
                exec = !(uop.last && out_busy);
                if (exec) n_pc = r_pc + 1'b1;
                if (exec && uop.last) n_valid = 1'b1;
            end
            default: o_stall = 1'b1;
        endcase
        o_cmd.load_x = (r_state == maf_pkg::ST_IDLE) && i_valid;
        o_cmd.exec   = exec;
        o_cmd.uop    = uop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= maf_pkg::ST_IDLE;
            r_pc    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_valid <= n_valid;
        end
    end

endmodule

>>> rtl/maf_dp.sv
// Datapath of the multimode audio filter: filter state, scratch registers and one
// saturating add/subtract/multiply unit. Depends on maf_pkg.
`timescale 1ns / 1ps

module maf_dp #(
    parameter int SAMPLE_BITS    = 24,
    parameter int STATE_BITS     = 32,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clr,
    input  maf_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic [maf_pkg::COEF_W-1:0]        i_gcoef,
    input  logic [maf_pkg::COEF_W-1:0]        i_lcoef,
    input  logic [maf_pkg::COEF_W-1:0]        i_damp,
    input  logic [maf_pkg::COEF_W-1:0]        i_k095,
    input  logic [maf_pkg::COEF_W-1:0]        i_k099,
    input  logic [maf_pkg::COEF_W-1:0]        i_res4,
    output logic signed [SAMPLE_BITS-1:0]     o_sample,
    output logic                              o_clipped
);

    localparam int N  = STATE_BITS;
    localparam int PW = STATE_BITS + maf_pkg::COEF_W + 1;
    localparam logic signed [N+1:0] SUM_MAX = (N+2)'((64'sd1 <<< (N-1)) - 1);
    localparam logic signed [N+1:0] SUM_MIN = -SUM_MAX - 1;
    localparam logic [PW-1:0] MAG_MAX = (PW'(1) << (N-1)) - PW'(1);
    localparam logic signed [N-1:0] ST_MAX = SUM_MAX[N-1:0];
    localparam logic signed [N-1:0] ST_MIN = SUM_MIN[N-1:0];
    localparam logic signed [N-1:0] SMP_MAX = N'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
    localparam logic signed [N-1:0] SMP_MIN = -SMP_MAX - 1;

    logic signed [N-1:0] r_x, r_slo, r_sbp, r_d0, r_d1, r_d2, r_d3;
    logic signed [N-1:0] r_thp, r_tl1, r_tl2, r_ihi, r_ilo;
    logic signed [N-1:0] r_o0, r_o1, r_o2, r_o3, r_t0, r_t1, r_t2;
    logic                r_clip;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic                r_out_clip;

    logic signed [N-1:0]   va, vb, vc, res, yclamp;
    logic signed [N+1:0]   sum;
    logic [maf_pkg::COEF_W-1:0] coef;
    logic                  shift16, neg, ovf, yovf;
    logic [N-1:0]          mag;
    logic [PW-1:0]         prod, rnd;

    function automatic logic signed [N-1:0] rd(input maf_pkg::t_reg sel,
        input logic signed [N-1:0] x, input logic signed [N-1:0] slo,
        input logic signed [N-1:0] sbp, input logic signed [N-1:0] d0,
        input logic signed [N-1:0] d1, input logic signed [N-1:0] d2,
        input logic signed [N-1:0] d3, input logic signed [N-1:0] thp,
        input logic signed [N-1:0] tl1, input logic signed [N-1:0] tl2,
        input logic signed [N-1:0] ihi, input logic signed [N-1:0] ilo,
        input logic signed [N-1:0] o0, input logic signed [N-1:0] o1,
        input logic signed [N-1:0] o2, input logic signed [N-1:0] o3,
        input logic signed [N-1:0] t0, input logic signed [N-1:0] t1,
        input logic signed [N-1:0] t2);
        logic signed [N-1:0] v;
        begin
            case (sel)
                maf_pkg::R_X:   v = x;
                maf_pkg::R_SLO: v = slo;
                maf_pkg::R_SBP: v = sbp;
                maf_pkg::R_D0:  v = d0;
                maf_pkg::R_D1:  v = d1;
                maf_pkg::R_D2:  v = d2;
                maf_pkg::R_D3:  v = d3;
                maf_pkg::R_THP: v = thp;
                maf_pkg::R_TL1: v = tl1;
                maf_pkg::R_TL2: v = tl2;
                maf_pkg::R_IHI: v = ihi;
                maf_pkg::R_ILO: v = ilo;
                maf_pkg::R_O0:  v = o0;
                maf_pkg::R_O1:  v = o1;
                maf_pkg::R_O2:  v = o2;
                maf_pkg::R_O3:  v = o3;
                maf_pkg::R_T0:  v = t0;
                maf_pkg::R_T1:  v = t1;
                maf_pkg::R_T2:  v = t2;
                default:        v = '0;
            endcase
            rd = v;
        end
    endfunction

    assign va = rd(i_cmd.uop.a, r_x, r_slo, r_sbp, r_d0, r_d1, r_d2, r_d3, r_thp, r_tl1,
                   r_tl2, r_ihi, r_ilo, r_o0, r_o1, r_o2, r_o3, r_t0, r_t1, r_t2);
    assign vb = rd(i_cmd.uop.b, r_x, r_slo, r_sbp, r_d0, r_d1, r_d2, r_d3, r_thp, r_tl1,
                   r_tl2, r_ihi, r_ilo, r_o0, r_o1, r_o2, r_o3, r_t0, r_t1, r_t2);
    assign vc = rd(i_cmd.uop.c, r_x, r_slo, r_sbp, r_d0, r_d1, r_d2, r_d3, r_thp, r_tl1,
                   r_tl2, r_ihi, r_ilo, r_o0, r_o1, r_o2, r_o3, r_t0, r_t1, r_t2);

    always_comb begin
        case (i_cmd.uop.coef)
            maf_pkg::C_G:    coef = i_gcoef;
            maf_pkg::C_L:    coef = i_lcoef;
            maf_pkg::C_DAMP: coef = i_damp;
            maf_pkg::C_K095: coef = i_k095;
            maf_pkg::C_K099: coef = i_k099;
            maf_pkg::C_RES4: coef = i_res4;
            default:         coef = i_gcoef;
        endcase
        shift16 = !(i_cmd.uop.coef == maf_pkg::C_G || i_cmd.uop.coef == maf_pkg::C_L);

        // magnitude product, rounded half away from zero
        neg  = va[N-1];
        mag  = neg ? N'(-va) : N'(va);
        prod = PW'(mag) * PW'(coef);
        if (shift16)
            rnd = (prod + (PW'(1) << (maf_pkg::Q16_FRAC - 1))) >> maf_pkg::Q16_FRAC;
        else
            rnd = (prod + (PW'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;

        sum = '0;
        res = '0;
        ovf = 1'b0;
        case (i_cmd.uop.op)
            maf_pkg::OP_ADD: sum = (N+2)'(va) + (N+2)'(vb);
            maf_pkg::OP_SUB: sum = (N+2)'(va) - (N+2)'(vb) - (N+2)'(vc);
            default:         sum = '0;
        endcase
        if (i_cmd.uop.op == maf_pkg::OP_MUL) begin
            if (!neg && rnd > MAG_MAX) begin
                res = ST_MAX;
                ovf = 1'b1;
            end else if (neg && rnd > MAG_MAX + PW'(1)) begin
                res = ST_MIN;
                ovf = 1'b1;
            end else begin
                res = neg ? -N'(rnd) : N'(rnd);
            end
        end else if (sum > SUM_MAX) begin
            res = ST_MAX;
            ovf = 1'b1;
        end else if (sum < SUM_MIN) begin
            res = ST_MIN;
            ovf = 1'b1;
        end else begin
            res = sum[N-1:0];
        end

        yovf = 1'b1;
        if (va > SMP_MAX)      yclamp = SMP_MAX;
        else if (va < SMP_MIN) yclamp = SMP_MIN;
        else begin
            yclamp = va;
            yovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_slo <= '0; r_sbp <= '0;
            r_d0  <= '0; r_d1  <= '0; r_d2 <= '0; r_d3 <= '0;
            r_thp <= '0; r_tl1 <= '0; r_tl2 <= '0;
            r_ihi <= '0; r_ilo <= '0;
            r_o0  <= '0; r_o1  <= '0; r_o2 <= '0; r_o3 <= '0;
        end else if (i_cmd.exec && i_cmd.uop.op != maf_pkg::OP_OUT) begin
            case (i_cmd.uop.dst)
                maf_pkg::R_SLO: r_slo <= res;
                maf_pkg::R_SBP: r_sbp <= res;
                maf_pkg::R_D0:  r_d0  <= res;
                maf_pkg::R_D1:  r_d1  <= res;
                maf_pkg::R_D2:  r_d2  <= res;
                maf_pkg::R_D3:  r_d3  <= res;
                maf_pkg::R_THP: r_thp <= res;
                maf_pkg::R_TL1: r_tl1 <= res;
                maf_pkg::R_TL2: r_tl2 <= res;
                maf_pkg::R_IHI: r_ihi <= res;
                maf_pkg::R_ILO: r_ilo <= res;
                maf_pkg::R_O0:  r_o0  <= res;
                maf_pkg::R_O1:  r_o1  <= res;
                maf_pkg::R_O2:  r_o2  <= res;
                maf_pkg::R_O3:  r_o3  <= res;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x    <= N'(i_sample);
            r_clip <= 1'b0;
        end else if (i_cmd.exec) begin
            r_clip <= r_clip | (ovf && i_cmd.uop.op != maf_pkg::OP_OUT);
            case (i_cmd.uop.dst)
                maf_pkg::R_T0: if (i_cmd.uop.op != maf_pkg::OP_OUT) r_t0 <= res;
                maf_pkg::R_T1: if (i_cmd.uop.op != maf_pkg::OP_OUT) r_t1 <= res;
                maf_pkg::R_T2: if (i_cmd.uop.op != maf_pkg::OP_OUT) r_t2 <= res;
                default: ;
            endcase
            if (i_cmd.uop.op == maf_pkg::OP_OUT) begin
                r_out      <= yclamp[SAMPLE_BITS-1:0];
                r_out_clip <= r_clip | yovf;
            end
        end
    end

    assign o_sample  = r_out;
    assign o_clipped = r_out_clip;

endmodule

>>> rtl/multimode_audio_filter.sv
// Top level of the multimode audio filter: configuration registers and derived
// coefficients, sequencer and datapath. Depends on maf_pkg, maf_ctrl and maf_dp.
`timescale 1ns / 1ps

// One sample in, one filtered sample out. A sample is taken in and then worked
// through the step list of the active model, one step at a time, all on a single
// shared multiply/add unit: 7 to 8 steps for the state variable filter, 7 for
// the two-pole, 6 to 7 for the two-integrator and 16 for either ladder. The
// output register lets the next sample start while the last result waits.
// Writing a different oversampling factor clears all filter state at once.
// Configure only while idle.
module multimode_audio_filter #(
    parameter int SAMPLE_BITS    = 24,
    parameter int STATE_BITS     = 32,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [maf_pkg::COEF_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_clipped
);

    localparam int RW = maf_pkg::RES_W;
    localparam int CW = maf_pkg::COEF_W;

    logic [2:0]    r_model;
    logic [1:0]    r_resp;
    logic [2:0]    r_osf;
    logic [CW-1:0] r_gcoef, r_lcoef;
    logic [RW-1:0] r_k099, r_k095, r_damp, r_res;
    logic          r_clr;

    logic [2:0]    osf_new;
    logic [RW-1:0] res_new;
    maf_pkg::t_model  model_eff;
    maf_pkg::t_dp_cmd cmd;

    always_comb begin
        osf_new = i_cfg_data[2:0];
        if (osf_new < 3'd1) osf_new = 3'd1;
        if (osf_new > 3'd4) osf_new = 3'd4;
        res_new = i_cfg_data[RW-1:0];
        if (res_new > maf_pkg::Q16_ONE) res_new = maf_pkg::Q16_ONE;

        // unused model codes and factor one fall back to the state variable filter
        if (r_osf == 3'd1 || r_model > 3'd4) model_eff = maf_pkg::MDL_SVF;
        else                                 model_eff = maf_pkg::t_model'(r_model);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= '0;
            r_resp  <= '0;
            r_osf   <= 3'd1;
            r_gcoef <= '0;
            r_lcoef <= '0;
            r_res   <= '0;
            r_k099  <= '0;
            r_k095  <= '0;
            r_damp  <= maf_pkg::Q16_ONE;
            r_clr   <= 1'b0;
        end else begin
            r_clr <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    maf_pkg::CFG_MODEL: r_model <= i_cfg_data[2:0];
                    maf_pkg::CFG_RESP:  r_resp  <= i_cfg_data[1:0];
                    maf_pkg::CFG_OSF: begin
                        r_osf <= osf_new;
                        r_clr <= (osf_new != r_osf);
                    end
                    maf_pkg::CFG_GCOEF: r_gcoef <= i_cfg_data;
                    maf_pkg::CFG_LCOEF: r_lcoef <= i_cfg_data;
                    maf_pkg::CFG_RES: begin
                        r_res  <= res_new;
                        r_k099 <= maf_pkg::q16_scale(res_new, maf_pkg::K_099);
                        r_k095 <= maf_pkg::q16_scale(res_new, maf_pkg::K_095);
                        r_damp <= maf_pkg::Q16_ONE -
                                  maf_pkg::q16_scale(res_new, maf_pkg::K_099);
                    end
                    default: ;
                endcase
            end
        end
    end

    maf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_model (model_eff),
        .i_resp  (maf_pkg::t_resp'(r_resp)),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    maf_dp #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .STATE_BITS     (STATE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (r_clr),
        .i_cmd     (cmd),
        .i_sample  (i_sample_in),
        .i_gcoef   (r_gcoef),
        .i_lcoef   (r_lcoef),
        .i_damp    (CW'(r_damp)),
        .i_k095    (CW'(r_k095)),
        .i_k099    (CW'(r_k099)),
        .i_res4    (CW'({r_res, 2'b00})),
        .o_sample  (o_sample_out),
        .o_clipped (o_clipped)
    );

endmodule

>>> rtl/maf_checker.sv
// Port-level checks for the multimode audio filter, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module maf_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [SAMPLE_BITS-1:0] o_sample_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample_out))
        else $error("result dropped or changed while stalled");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken without going busy");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared with no request in progress");

    a_done_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_stall) |-> o_valid)
        else $error("went idle without a result");

endmodule

bind multimode_audio_filter maf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_maf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_sample_out (o_sample_out)
);
